// ===== sv/integer_alu_32_top_defines.svh =====
// Assertion macros for the integer ALU.
`ifndef INTEGER_ALU_32_TOP_DEFINES_SVH
`define INTEGER_ALU_32_TOP_DEFINES_SVH
// Assert that a implies b on the next edge.
`define IALU_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
// Assert that a implies b on the same edge.
`define IALU_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`endif

// ===== sv/ialu_pkg.sv =====
// Shared types, opcodes and constants for the integer ALU.
package ialu_pkg;
   localparam int unsigned XLEN = 32;
   localparam int unsigned DEPTH = XLEN + 3;
   typedef logic [XLEN-1:0] word_type;
   typedef logic [4:0] op_type;
   localparam op_type OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MULL = 5'd2, OP_MULH = 5'd3;
   localparam op_type OP_MULLU = 5'd4, OP_MULHU = 5'd5, OP_DIV = 5'd6, OP_DIVU = 5'd7;
   localparam op_type OP_REMU = 5'd8, OP_AND = 5'd9, OP_OR = 5'd10, OP_NOT = 5'd11;
   localparam op_type OP_XOR = 5'd12, OP_ROR = 5'd13, OP_SRL = 5'd14, OP_SRA = 5'd15;
   localparam op_type OP_SLL = 5'd16, OP_SLT = 5'd17, OP_SLTU = 5'd18, OP_ADDI = 5'd19;
   localparam op_type OP_SUBI = 5'd20, OP_SLTI = 5'd21, OP_SLTIU = 5'd22;
   typedef struct packed {
      logic     valid;
      op_type   op;
      word_type a;
      word_type b;
      word_type rem;
      word_type quo;
      logic [2*XLEN-1:0] prod;
      logic     neg_q;
      logic     neg_p;
      word_type res;
      logic     bad;
   } beat_type;
endpackage

// ===== sv/ialu_cell.sv =====
// One cell of the ALU chain: one step of the shared multiply/divide sweep.
module ialu_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ialu_pkg::beat_type up,
   input  logic [5:0]        idx,
   output ialu_pkg::beat_type down
);
   import ialu_pkg::*;
   beat_type                   down_ff, down_in;
   logic [XLEN:0]              trial;
   logic [2*XLEN-1:0]          pp;
   logic                       md;
   always_comb begin
      down_in = up;
      md = (up.op == OP_DIV) || (up.op == OP_DIVU) || (up.op == OP_REMU);
      trial = {up.rem, up.a[XLEN-1]} - {1'b0, up.b};
      pp = up.b[idx[4:0]] ? ({{XLEN{1'b0}}, up.a} << idx[4:0]) : '0;
      if (idx < 6'(XLEN)) begin
         if (md) begin
            down_in.a = {up.a[XLEN-2:0], 1'b0};
            if (!trial[XLEN]) begin
               down_in.rem = trial[XLEN-1:0];
               down_in.quo = {up.quo[XLEN-2:0], 1'b1};
            end else begin
               down_in.rem = {up.rem[XLEN-2:0], up.a[XLEN-1]};
               down_in.quo = {up.quo[XLEN-2:0], 1'b0};
            end
         end else begin
            down_in.prod = up.prod + pp;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff.valid <= 1'b0;
      end else if (advance) begin
         down_ff.valid <= up.valid;
      end
      if (advance) begin
         down_ff.op <= down_in.op; down_ff.a <= down_in.a; down_ff.b <= down_in.b;
         down_ff.rem <= down_in.rem; down_ff.quo <= down_in.quo;
         down_ff.prod <= down_in.prod; down_ff.neg_q <= down_in.neg_q;
         down_ff.neg_p <= down_in.neg_p; down_ff.res <= down_in.res;
         down_ff.bad <= down_in.bad;
      end
   end
   assign down = down_ff;
endmodule

// ===== sv/integer_alu_32_top.sv =====
// Top level of the pipelined 32-bit integer ALU.
// Accepts one instruction per cycle, back to back, while req_stall is low. The decode logic
// feeds a 35-cell chain combinationally. The first 32 cells each retire one quotient or
// partial-product bit, and the last three only carry the beat. One output register follows
// the chain. The chain and the output register stall as a whole while the output register
// holds a result and rsp_stall is high. In those cycles req_stall is high.
module integer_alu_32_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [4:0]          req_op,
   input  logic [31:0]         req_a,
   input  logic [31:0]         req_b,
   input  logic signed [16:0]  req_imm,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_result,
   output logic                rsp_bad_op
);
   import ialu_pkg::*;
`include "integer_alu_32_top_defines.svh"
   beat_type  chain [0:DEPTH-1];
   beat_type  head;
   beat_type  out_in;
   logic      out_valid_ff;
   word_type  out_res_ff;
   logic      out_bad_ff;
   logic      advance;
   word_type  imm, ma, mb, sh;
   assign advance = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;
   always_comb begin
      imm = {{(XLEN-17){req_imm[16]}}, req_imm};
      ma = req_a; mb = req_b;
      if (req_op == OP_DIV || req_op == OP_MULL || req_op == OP_MULH) begin
         ma = req_a[XLEN-1] ? -req_a : req_a;
         mb = req_b[XLEN-1] ? -req_b : req_b;
      end
      head = '0;
      head.valid = req_valid;
      head.op = req_op;
      head.a = ma;
      head.b = mb;
      head.neg_q = req_a[XLEN-1] ^ req_b[XLEN-1];
      head.neg_p = req_a[XLEN-1] ^ req_b[XLEN-1];
      sh = {27'd0, req_b[4:0]};
      unique case (req_op) inside
         OP_ADD:   head.res = req_a + req_b;
         OP_SUB:   head.res = req_a - req_b;
         OP_AND:   head.res = req_a & req_b;
         OP_OR:    head.res = req_a | req_b;
         OP_NOT:   head.res = ~req_a;
         OP_XOR:   head.res = req_a ^ req_b;
         OP_ROR:   head.res = (req_a >> sh) | (req_a << (6'd32 - {1'b0, req_b[4:0]}));
         OP_SRL:   head.res = req_a >> sh;
         OP_SRA:   head.res = word_type'($signed(req_a) >>> sh);
         OP_SLL:   head.res = req_a << sh;
         OP_SLT:   head.res = word_type'($signed(req_a) < $signed(req_b));
         OP_SLTU:  head.res = word_type'(req_a < req_b);
         OP_ADDI:  head.res = req_a + imm;
         OP_SUBI:  head.res = req_a - imm;
         OP_SLTI:  head.res = word_type'($signed(req_a) < $signed(imm));
         OP_SLTIU: head.res = word_type'(req_a < imm);
         OP_MULL, OP_MULH, OP_MULLU, OP_MULHU, OP_DIV, OP_DIVU, OP_REMU:
            head.res = req_a;
         default: begin
            head.res = '0;
            head.bad = 1'b1;
         end
      endcase
      if (req_op == OP_ROR && req_b[4:0] == 5'd0) head.res = req_a;
   end
   genvar g;
   for (g = 0; g < DEPTH; g++) begin : g_cell
      ialu_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .up((g == 0) ? head : chain[(g == 0) ? 0 : g-1]),
         .idx(6'(g)), .down(chain[g])
      );
   end
   always_comb begin
      out_in = chain[DEPTH-1];
      case (out_in.op) inside
         OP_MULLU: out_in.res = out_in.prod[XLEN-1:0];
         OP_MULHU: out_in.res = out_in.prod[2*XLEN-1:XLEN];
         OP_MULL, OP_MULH: begin
            out_in.prod = out_in.neg_p ? -out_in.prod : out_in.prod;
            out_in.res = (out_in.op == OP_MULL) ? out_in.prod[XLEN-1:0]
                                                : out_in.prod[2*XLEN-1:XLEN];
         end
         OP_DIVU:  out_in.res = out_in.quo;
         OP_REMU:  out_in.res = (out_in.b == '0) ? out_in.res : out_in.rem;
         OP_DIV:   out_in.res = (out_in.b == '0) ? '1
                                : (out_in.neg_q ? -out_in.quo : out_in.quo);
         default: ;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_in.valid;
      end
      if (advance) begin
         out_res_ff <= out_in.res;
         out_bad_ff <= out_in.bad;
      end
   end
   assign rsp_valid = out_valid_ff;
   assign rsp_result = out_res_ff;
   assign rsp_bad_op = out_bad_ff;
   `IALU_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result))
   `IALU_ASSERT_NOW(a_bad_zero, clock, reset, rsp_valid && rsp_bad_op, rsp_result == '0)
   `IALU_ASSERT_NOW(a_stall_link, clock, reset, req_stall, rsp_valid && rsp_stall)
endmodule
